FILE: rtl/core/gasc_pkg.sv
package gasc_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 16;

    localparam logic [1:0] KIND_LOOKUP  = 2'd0;
    localparam logic [1:0] KIND_CLEAR   = 2'd1;
    localparam logic [1:0] KIND_RESERVE = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_SPACE = 2'd2;

    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam logic [15:0] LAYER_MAX = 16'hffff;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] glyph;
        logic [63:0] extra_ids;
        logic [7:0]  lig_cell;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [15:0] slot_x;
        logic [15:0] slot_y;
        logic [15:0] slot_layer;
        logic [1:0]  error_code;
        logic [15:0] rows_used;
        logic [15:0] layers_used;
    } t_out_item;

    typedef struct packed {
        logic [15:0] glyph;
        logic [63:0] extra;
        logic [7:0]  ligature;
        logic [15:0] col;
        logic [15:0] row;
        logic [15:0] layer;
    } t_entry;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [15:0] layer;
        logic [15:0] used_rows;
    } t_cursor;

    typedef struct packed {
        logic restart;
        logic advance;
    } t_cur_ctl;

    typedef struct packed {
        logic ent_rd;
        logic ent_wr;
        logic fill_rd;
        logic fill_wr;
    } t_store_ctl;

endpackage

FILE: rtl/core/glyph_atlas_slot_cache.sv
// Channel   Direction  Signals                              Item
// input     in         i_in_valid / o_in_ready / i_in_item  kind, glyph, extra, ligature
// output    out        o_out_valid / i_out_ready / o_out_item  hit, slot, error, usage
// config    in/out     psel penable pwrite paddr pwdata prdata pready  three 16-bit registers
//
// A lookup passes hash, bucket and fill read, then scans the filled ways; a hit answers from
// compare, a full bucket from scan and an insert from advance. One compare unit walks the
// ways of the bucket, one entry memory read per way. Reserve and unused kinds answer from
// the advance and done states; a table clear writes one bucket a cycle, the last once the
// output is free. The input is ready again once the result is loaded. After reset a
// clearing pass over all buckets runs before the first item is accepted.
// A result waits in the output register; the sequencer holds its last step while it is full.
module glyph_atlas_slot_cache #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gasc_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gasc_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gasc_pkg::ADDR_W-1:0]   paddr,
    input  logic [gasc_pkg::DATA_W-1:0]   pwdata,
    output logic [gasc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import gasc_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(BUCKETS * WAYS);
    localparam int WW = $clog2(WAYS + 1);
    // Exact quotient of a 16-bit glyph by BUCKETS through a reciprocal.
    localparam int SHIFT = 16 + BW;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + BUCKETS - 1) / BUCKETS;
    localparam int MW = $clog2(RECIP + 1);
    localparam int PW = 16 + MW;

    typedef enum logic [9:0] {
        ST_INIT  = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_HASH  = 10'b00_0000_0100,
        ST_BKT   = 10'b00_0000_1000,
        ST_FREAD = 10'b00_0001_0000,
        ST_SCAN  = 10'b00_0010_0000,
        ST_CMP   = 10'b00_0100_0000,
        ST_ADV   = 10'b00_1000_0000,
        ST_CLEAR = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    t_in_item      r_item;
    logic          r_insert;
    logic [BW-1:0] r_clr;
    logic [15:0]   r_quot;
    logic [BW-1:0] r_bucket;
    logic [EW-1:0] r_base;
    logic [WW-1:0] r_way;
    logic          r_out_valid;
    t_out_item     r_out_item;
    logic [15:0]   r_cols;
    logic [15:0]   r_rows;
    logic [15:0]   r_limit;

    logic          w_cfg_wr;
    logic [1:0]    w_cfg_idx;
    logic          w_out_free;
    logic          w_load;
    t_out_item     w_res;
    logic [PW-1:0] w_prod;
    logic [31:0]   w_qb;
    logic          w_match;
    logic          w_clr_last;
    logic [EW-1:0] w_ent_addr;
    logic [BW-1:0] w_fill_waddr;
    logic [WW-1:0] w_fill_wdata;
    t_entry        w_ent_wdata;
    t_entry        w_ent_rdata;
    logic [WW-1:0] w_fill;
    t_store_ctl    w_st_ctl;
    t_cur_ctl      w_cur_ctl;
    t_cursor       w_cur;
    t_cursor       w_cur_next;
    logic          w_space;

    // Configuration port.
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (w_cfg_idx)
            REG_COLS:  prdata = {{(DATA_W-CFG_W){1'b0}}, r_cols};
            REG_ROWS:  prdata = {{(DATA_W-CFG_W){1'b0}}, r_rows};
            REG_LIMIT: prdata = {{(DATA_W-CFG_W){1'b0}}, r_limit};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= 16'd1;
            r_rows  <= 16'd1;
            r_limit <= 16'd0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_COLS:  r_cols  <= pwdata[CFG_W-1:0];
                REG_ROWS:  r_rows  <= pwdata[CFG_W-1:0];
                REG_LIMIT: r_limit <= pwdata[CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    // Arithmetic and compare.
    assign w_prod     = PW'(r_item.glyph) * PW'(RECIP);
    assign w_qb       = 32'(r_quot) * 32'(BUCKETS);
    assign w_ent_addr = r_base + EW'(r_way);
    assign w_match    = (w_ent_rdata.glyph == r_item.glyph) &&
                        (w_ent_rdata.extra == r_item.extra_ids) &&
                        (w_ent_rdata.ligature == r_item.lig_cell);
    assign w_clr_last = (r_clr == BW'(BUCKETS - 1));
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_ent_wdata = '{glyph: r_item.glyph, extra: r_item.extra_ids,
                           ligature: r_item.lig_cell, col: w_cur.col,
                           row: w_cur.row, layer: w_cur.layer};

    always_comb begin
        n_state      = r_state;
        w_load       = 1'b0;
        w_st_ctl     = '0;
        w_cur_ctl    = '0;
        w_fill_waddr = r_bucket;
        w_fill_wdata = w_fill + WW'(1);
        w_res        = '0;
        w_res.error_code  = ERR_OK;
        w_res.rows_used   = w_cur.used_rows;
        w_res.layers_used = w_cur.layer;
        w_cur_ctl.restart = w_cfg_wr &&
                            ((w_cfg_idx == REG_COLS) || (w_cfg_idx == REG_ROWS));

        case (r_state)
            ST_INIT: begin
                w_st_ctl.fill_wr = 1'b1;
                w_fill_waddr     = r_clr;
                w_fill_wdata     = '0;
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.kind)
                        KIND_LOOKUP:  n_state = ST_HASH;
                        KIND_CLEAR:   n_state = ST_CLEAR;
                        KIND_RESERVE: n_state = ST_ADV;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_HASH: n_state = ST_BKT;
            ST_BKT:  n_state = ST_FREAD;
            ST_FREAD: begin
                w_st_ctl.fill_rd = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_way != w_fill) begin
                    w_st_ctl.ent_rd = 1'b1;
                    n_state         = ST_CMP;
                end else if (w_fill != WW'(WAYS)) begin
                    n_state = ST_ADV;
                end else if (w_out_free) begin
                    w_res.error_code = ERR_FULL;
                    w_load           = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (!w_match) begin
                    n_state = ST_SCAN;
                end else if (w_out_free) begin
                    w_res.hit        = 1'b1;
                    w_res.slot_x     = w_ent_rdata.col;
                    w_res.slot_y     = w_ent_rdata.row;
                    w_res.slot_layer = w_ent_rdata.layer;
                    w_load           = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_ADV: begin
                if (w_out_free) begin
                    w_cur_ctl.advance = 1'b1;
                    w_st_ctl.ent_wr   = r_insert;
                    w_st_ctl.fill_wr  = r_insert;
                    w_res.slot_x      = w_cur.col;
                    w_res.slot_y      = w_cur.row;
                    w_res.slot_layer  = w_cur.layer;
                    w_res.error_code  = w_space ? ERR_SPACE : ERR_OK;
                    w_res.rows_used   = w_cur_next.used_rows;
                    w_res.layers_used = w_cur_next.layer;
                    w_load            = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                w_fill_waddr = r_clr;
                w_fill_wdata = '0;
                if (!w_clr_last) begin
                    w_st_ctl.fill_wr = 1'b1;
                end else if (w_out_free) begin
                    w_st_ctl.fill_wr = 1'b1;
                    w_load           = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The bucket counter holds on the last bucket while the result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_clr <= '0;
            end else if ((r_state == ST_INIT) ||
                         ((r_state == ST_CLEAR) && w_st_ctl.fill_wr)) begin
                r_clr <= r_clr + BW'(1);
            end
        end
    end

    // Item and lookup datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_item   <= i_in_item;
                    r_insert <= (i_in_item.kind == KIND_LOOKUP);
                end
            end
            ST_HASH:  r_quot   <= 16'(w_prod >> SHIFT);
            ST_BKT:   r_bucket <= BW'(r_item.glyph - w_qb[15:0]);
            ST_FREAD: begin
                r_base <= EW'(r_bucket) * EW'(WAYS);
                r_way  <= '0;
            end
            ST_CMP: begin
                if (!w_match) begin
                    r_way <= r_way + WW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= w_res;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    gasc_store #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (w_st_ctl),
        .i_ent_addr   (w_ent_addr),
        .i_ent_wdata  (w_ent_wdata),
        .o_ent_rdata  (w_ent_rdata),
        .i_fill_raddr (r_bucket),
        .i_fill_waddr (w_fill_waddr),
        .i_fill_wdata (w_fill_wdata),
        .o_fill_rdata (w_fill)
    );

    gasc_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cur_ctl),
        .i_cols  (r_cols),
        .i_rows  (r_rows),
        .i_limit (r_limit),
        .o_cur   (w_cur),
        .o_next  (w_cur_next),
        .o_space (w_space)
    );

endmodule

FILE: rtl/core/gasc_store.sv
module gasc_store #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic                              i_clk,
    input  gasc_pkg::t_store_ctl              i_ctl,
    input  logic [$clog2(BUCKETS*WAYS)-1:0]   i_ent_addr,
    input  gasc_pkg::t_entry                  i_ent_wdata,
    output gasc_pkg::t_entry                  o_ent_rdata,
    input  logic [$clog2(BUCKETS)-1:0]        i_fill_raddr,
    input  logic [$clog2(BUCKETS)-1:0]        i_fill_waddr,
    input  logic [$clog2(WAYS+1)-1:0]         i_fill_wdata,
    output logic [$clog2(WAYS+1)-1:0]         o_fill_rdata
);
    import gasc_pkg::*;

    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int WW      = $clog2(WAYS + 1);

    // Ways of a bucket fill from way 0 upward, so one count per bucket
    // stands in for the per-entry valid bits.
    t_entry     r_ent_mem  [ENTRIES];
    logic [WW-1:0] r_fill_mem [BUCKETS];
    t_entry     r_ent_rdata;
    logic [WW-1:0] r_fill_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ent_wr) begin
            r_ent_mem[i_ent_addr] <= i_ent_wdata;
        end
        if (i_ctl.ent_rd) begin
            r_ent_rdata <= r_ent_mem[i_ent_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill_wr) begin
            r_fill_mem[i_fill_waddr] <= i_fill_wdata;
        end
        if (i_ctl.fill_rd) begin
            r_fill_rdata <= r_fill_mem[i_fill_raddr];
        end
    end

    assign o_ent_rdata  = r_ent_rdata;
    assign o_fill_rdata = r_fill_rdata;

endmodule

FILE: rtl/core/gasc_cursor.sv
module gasc_cursor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gasc_pkg::t_cur_ctl i_ctl,
    input  logic [15:0]        i_cols,
    input  logic [15:0]        i_rows,
    input  logic [15:0]        i_limit,
    output gasc_pkg::t_cursor  o_cur,
    output gasc_pkg::t_cursor  o_next,
    output logic               o_space
);
    import gasc_pkg::*;

    t_cursor     r_cur;
    t_cursor     n_cur;
    logic [15:0] w_cols;
    logic [15:0] w_rows;
    logic [15:0] w_col1;
    logic [15:0] w_row1;
    logic [16:0] w_want;
    logic [16:0] w_want_lim;
    logic [15:0] w_layer1;
    logic        w_wrap_col;
    logic        w_wrap_row;

    // A size of zero behaves as a size of one.
    assign w_cols = (i_cols == 16'd0) ? 16'd1 : i_cols;
    assign w_rows = (i_rows == 16'd0) ? 16'd1 : i_rows;

    always_comb begin
        w_col1     = r_cur.col + 16'd1;
        w_row1     = r_cur.row + 16'd1;
        w_wrap_col = (w_col1 >= w_cols);
        w_wrap_row = (w_row1 >= w_rows);
        w_want     = {1'b0, w_row1} + 17'd1;
        if ({1'b0, r_cur.used_rows} > w_want) begin
            w_want = {1'b0, r_cur.used_rows};
        end
        w_want_lim = (w_want > {1'b0, w_rows}) ? {1'b0, w_rows} : w_want;
        w_layer1   = (r_cur.layer == LAYER_MAX) ? r_cur.layer : r_cur.layer + 16'd1;

        n_cur   = r_cur;
        o_space = 1'b0;
        n_cur.col = w_col1;
        if (w_wrap_col) begin
            n_cur.col       = 16'd0;
            n_cur.row       = w_row1;
            n_cur.used_rows = w_want_lim[15:0];
            if (w_wrap_row) begin
                n_cur.row   = 16'd0;
                n_cur.layer = w_layer1;
                o_space     = (w_layer1 >= i_limit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_cur <= '{col: 16'd0, row: 16'd0, layer: 16'd0, used_rows: 16'd1};
        end else if (i_ctl.advance) begin
            r_cur <= n_cur;
        end
    end

    assign o_cur  = r_cur;
    assign o_next = n_cur;

endmodule

FILE: rtl/core/gasc_chk.sv
module gasc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input gasc_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gasc_pkg::t_out_item o_out_item
);
    import gasc_pkg::*;

    // A waiting result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // The input is never ready in the cycle after an accepted item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after an accepted item");

    // A hit never carries an error, and a full bucket returns no slot.
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.hit |-> o_out_item.error_code == ERR_OK)
        else $error("hit reported with an error code");

    a_full_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.error_code == ERR_FULL) |->
            !o_out_item.hit && (o_out_item.slot_x == 16'd0) &&
            (o_out_item.slot_y == 16'd0) && (o_out_item.slot_layer == 16'd0))
        else $error("bucket full result carries a slot");

    // The used-row count never drops below one.
    a_rows_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.rows_used != 16'd0)
        else $error("rows used reported as zero");

endmodule

bind glyph_atlas_slot_cache gasc_chk u_gasc_chk (.*);

FILE: verif/glyph_atlas_slot_cache_tb.sv
`timescale 1ns / 100ps

module glyph_atlas_slot_cache_tb;
    import gasc_pkg::*;

    localparam int NUM_BUCKETS  = 1024;
    localparam int NUM_WAYS     = 4;
    localparam int NUM_ENTRIES  = NUM_BUCKETS * NUM_WAYS;
    localparam int STALL_LIMIT  = 20000;
    localparam int KEY_POOL_MAX = 64;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_item   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_item;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    glyph_atlas_slot_cache #(
        .BUCKETS(NUM_BUCKETS),
        .WAYS   (NUM_WAYS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the slot table, the atlas cursor and the registers.
    bit          tag_valid [NUM_ENTRIES];
    logic [15:0] tag_glyph [NUM_ENTRIES];
    logic [63:0] tag_extra [NUM_ENTRIES];
    logic [7:0]  tag_lig   [NUM_ENTRIES];
    logic [15:0] tag_col   [NUM_ENTRIES];
    logic [15:0] tag_row   [NUM_ENTRIES];
    logic [15:0] tag_layer [NUM_ENTRIES];
    int unsigned cur_col     = 0;
    int unsigned cur_row     = 0;
    int unsigned cur_layer   = 0;
    int unsigned rows_in_use = 1;
    int unsigned cfg_cols    = 1;
    int unsigned cfg_rows    = 1;
    int unsigned cfg_limit   = 0;

    t_in_item  pending_items [$];
    t_out_item slots_due [$];
    t_in_item  key_pool [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fails         = 0;
    int stall_cycles  = 0;
    int n_results     = 0;
    int n_hits        = 0;
    int n_full        = 0;
    int n_space       = 0;

    function automatic void home_cursor();
        cur_col     = 0;
        cur_row     = 0;
        cur_layer   = 0;
        rows_in_use = 1;
    endfunction

    function automatic logic [1:0] bump_cursor();
        int unsigned cols;
        int unsigned rows;
        int unsigned want;
        logic [1:0]  err;
        cols = (cfg_cols == 0) ? 1 : cfg_cols;
        rows = (cfg_rows == 0) ? 1 : cfg_rows;
        err  = ERR_OK;
        cur_col = (cur_col + 1) & 16'hffff;
        if (cur_col >= cols) begin
            cur_col = 0;
            cur_row = (cur_row + 1) & 16'hffff;
            want = cur_row + 1;
            if (rows_in_use > want) want = rows_in_use;
            if (want > rows) want = rows;
            rows_in_use = want & 16'hffff;
            if (cur_row >= rows) begin
                cur_row = 0;
                // The layer saturates at its maximum rather than wrapping.
                if (cur_layer < LAYER_MAX) cur_layer++;
                if (cur_layer >= cfg_limit) err = ERR_SPACE;
            end
        end
        return err;
    endfunction

    function automatic t_out_item place_glyph(t_in_item it);
        t_out_item r;
        int        base;
        int        slot;
        bit        found;
        r     = '0;
        base  = (int'(it.glyph) % NUM_BUCKETS) * NUM_WAYS;
        slot  = -1;
        found = 1'b0;
        case (it.kind)
            KIND_LOOKUP: begin
                // Filled ways form a prefix, so the first empty way ends the search.
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (slot < 0) begin
                        if (!tag_valid[base + w]) begin
                            slot = base + w;
                        end else if (tag_glyph[base + w] == it.glyph &&
                                     tag_extra[base + w] == it.extra_ids &&
                                     tag_lig[base + w] == it.lig_cell) begin
                            slot  = base + w;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    r.hit        = 1'b1;
                    r.slot_x     = tag_col[slot];
                    r.slot_y     = tag_row[slot];
                    r.slot_layer = tag_layer[slot];
                end else if (slot >= 0) begin
                    tag_valid[slot] = 1'b1;
                    tag_glyph[slot] = it.glyph;
                    tag_extra[slot] = it.extra_ids;
                    tag_lig[slot]   = it.lig_cell;
                    tag_col[slot]   = 16'(cur_col);
                    tag_row[slot]   = 16'(cur_row);
                    tag_layer[slot] = 16'(cur_layer);
                    r.slot_x        = 16'(cur_col);
                    r.slot_y        = 16'(cur_row);
                    r.slot_layer    = 16'(cur_layer);
                    r.error_code    = bump_cursor();
                end else begin
                    r.error_code = ERR_FULL;
                end
            end
            KIND_CLEAR: begin
                foreach (tag_valid[i]) tag_valid[i] = 1'b0;
            end
            KIND_RESERVE: begin
                r.slot_x     = 16'(cur_col);
                r.slot_y     = 16'(cur_row);
                r.slot_layer = 16'(cur_layer);
                r.error_code = bump_cursor();
            end
            default: begin
            end
        endcase
        r.rows_used   = 16'(rows_in_use);
        r.layers_used = 16'(cur_layer);
        return r;
    endfunction

    // Driver: presents pending items and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                slots_due.push_back(place_glyph(i_in_item));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_item  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every result with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        string     names [7];
        logic [15:0] w [7];
        logic [15:0] g [7];
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (slots_due.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_item);
                    fails++;
                end else begin
                    want  = slots_due.pop_front();
                    names = '{"hit", "slot_x", "slot_y", "slot_layer", "error_code",
                              "rows_used", "layers_used"};
                    w = '{16'(want.hit), want.slot_x, want.slot_y, want.slot_layer,
                          16'(want.error_code), want.rows_used, want.layers_used};
                    g = '{16'(o_out_item.hit), o_out_item.slot_x, o_out_item.slot_y,
                          o_out_item.slot_layer, 16'(o_out_item.error_code),
                          o_out_item.rows_used, o_out_item.layers_used};
                    for (int i = 0; i < 7; i++) begin
                        if (g[i] !== w[i]) begin
                            $display("%0t: %s mismatch, expected %h actual %h",
                                     $time, names[i], w[i], g[i]);
                            fails++;
                        end
                    end
                    n_results++;
                    if (want.hit) n_hits++;
                    if (want.error_code == ERR_FULL) n_full++;
                    if (want.error_code == ERR_SPACE) n_space++;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COLS: begin
                cfg_cols = value & 16'hffff;
                home_cursor();
            end
            REG_ROWS: begin
                cfg_rows = value & 16'hffff;
                home_cursor();
            end
            REG_LIMIT: cfg_limit = value & 16'hffff;
            default: begin
            end
        endcase
    endtask

    task automatic set_atlas(input int unsigned cols, input int unsigned rows,
                             input int unsigned limit);
        write_reg(REG_COLS, cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_LIMIT, limit);
    endtask

    // Sample after the clock edge has settled so that an item just handed to the
    // driver is seen as valid.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_items.size() != 0 || i_in_valid || slots_due.size() != 0);
    endtask

    function automatic t_in_item make_item(logic [1:0] kind, logic [15:0] glyph,
                                           logic [63:0] extra, logic [7:0] lig);
        t_in_item it;
        it.kind      = kind;
        it.glyph     = glyph;
        it.extra_ids = extra;
        it.lig_cell  = lig;
        return it;
    endfunction

    // A few crowded buckets so that lookups find hits and fill buckets up.
    function automatic logic [9:0] hot_bucket();
        case ($urandom_range(0, 3))
            0:       return 10'h000;
            1:       return 10'h3ff;
            2:       return 10'h155;
            default: return 10'h2aa;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        int unsigned bitpos;
        bit          fresh;
        pick  = $urandom_range(0, 99);
        fresh = 1'b0;
        it = make_item(KIND_LOOKUP, 16'($urandom), {$urandom, $urandom}, 8'($urandom));
        if (pick < 45 && key_pool.size() != 0) begin
            it = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (pick < 52 && key_pool.size() != 0) begin
            // Near miss: a stored key with one bit flipped, same bucket.
            it     = key_pool[$urandom_range(0, key_pool.size() - 1)];
            bitpos = $urandom_range(0, 77);
            if (bitpos < 64) it.extra_ids[bitpos] = ~it.extra_ids[bitpos];
            else if (bitpos < 72) it.lig_cell[bitpos - 64] = ~it.lig_cell[bitpos - 64];
            else it.glyph[bitpos - 62] = ~it.glyph[bitpos - 62];
            fresh = 1'b1;
        end else if (pick < 77) begin
            it.glyph = {6'($urandom), hot_bucket()};
            fresh    = 1'b1;
        end else if (pick < 87) begin
            fresh = 1'b1;
        end else if (pick < 96) begin
            it.kind = KIND_RESERVE;
        end else if (pick < 97) begin
            it.kind = KIND_CLEAR;
        end else begin
            it.kind = KIND_UNUSED;
        end
        if (fresh) begin
            key_pool.push_back(it);
            if (key_pool.size() > KEY_POOL_MAX) void'(key_pool.pop_front());
        end
        return it;
    endfunction

    task automatic run_random(input int count);
        repeat (count) pending_items.push_back(random_item());
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first at the register reset values: every advance crosses
        // the zero layer limit.
        send_idle_pct = 15;
        recv_idle_pct = 77;
        pending_items.push_back(make_item(KIND_RESERVE, 16'h0000, '0, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0000, '0, 8'h00));
        wait_drained();

        set_atlas(2, 2, 1);
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0000, '0, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'hffff, '1, 8'hff));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'hffff, '1, 8'hff));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0400, '0, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0800, '0, 8'h00));
        // Fourth way of bucket zero; this insert lands on the layer limit.
        pending_items.push_back(make_item(KIND_LOOKUP, 16'hfc00, 64'h0123_4567_89ab_cdef,
                                          8'h80));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h1000, '0, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0000, '0, 8'h01));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0000, 64'h1, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0400, '0, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'hfc00, 64'h0123_4567_89ab_cdef,
                                          8'h80));
        repeat (4) pending_items.push_back(make_item(KIND_RESERVE, 16'h0000, '0, 8'h00));
        pending_items.push_back(make_item(KIND_UNUSED, 16'hffff, '1, 8'hff));
        pending_items.push_back(make_item(KIND_CLEAR, 16'h0000, '0, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0000, '0, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0400, '0, 8'h00));
        pending_items.push_back(make_item(KIND_LOOKUP, 16'h0000, '0, 8'h00));
        wait_drained();

        set_atlas(3, 2, 4);
        run_random(300);
        set_atlas(65535, 65535, 65535);
        run_random(200);

        send_idle_pct = 77;
        recv_idle_pct = 15;
        set_atlas(1, 65535, 0);
        run_random(300);
        set_atlas(5, 1, 2);
        run_random(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_atlas(2, 3, 65535);
        run_random(500);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results: %0d hits, %0d bucket-full, %0d out-of-space.",
                 n_results, n_hits, n_full, n_space);
        $display("Atlas sizes from 1 to 65535 cells, layer limits 0 to 65535, crowded buckets.");
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
